// ----- sv/round_trip_direction_histogram_macros.svh -----
// Assertion macros shared by the round-trip direction histogram RTL.
`ifndef ROUND_TRIP_DIRECTION_HISTOGRAM_MACROS_SVH
`define ROUND_TRIP_DIRECTION_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define RTDH_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTDH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RTDH_ASSERT_SAME(name, clk, rst, ante, cons, msg)
`define RTDH_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/rtdh_pkg.sv -----
// Shared types and constants of the round-trip direction histogram.
package rtdh_pkg;

   // Direction label codes.
   typedef enum logic [1:0] {
      LBL_NONE = 2'd0,
      LBL_UP   = 2'd1,
      LBL_DOWN = 2'd2
   } label_type;

   // Configuration register indexes.
   localparam logic CSR_TEMP_COUNT   = 1'b0;
   localparam logic CSR_LAMBDA_COUNT = 1'b1;

   localparam int CSR_WIDTH     = 7;
   localparam int REQ_WIDTH     = 6;
   localparam int REQ_VALUES    = 64;
   localparam int OUT_WIDTH     = 32;
   localparam int CLAMP_WIDTH   = 11;

   localparam logic [CSR_WIDTH-1:0] COUNT_RESET = 7'd64;

   localparam int DEF_MAX_REPLICAS = 64;
   localparam int DEF_MAX_TEMPS    = 64;
   localparam int DEF_MAX_LAMBDAS  = 64;
   localparam int DEF_COUNT_BITS   = 32;

endpackage

// ----- sv/round_trip_direction_histogram.sv -----
// Round-trip direction histogram: per-replica direction labels and per-index up/down counts.
// Throughput: one request per cycle unless the response stalls. A request is registered
// in the update stage, then in the response register. Each store does a read-modify-write
// per request: read at acceptance, write on leaving update, one-entry bypass for same entry.
// Reset (synchronous, active high) clears labels and counts at once through per-entry
// valid bits, and sets both ladder sizes to 64; no clearing pass is needed.
`include "round_trip_direction_histogram_macros.svh"
module round_trip_direction_histogram
   import rtdh_pkg::*;
#(
   parameter int MAX_REPLICAS = DEF_MAX_REPLICAS,
   parameter int MAX_TEMPS    = DEF_MAX_TEMPS,
   parameter int MAX_LAMBDAS  = DEF_MAX_LAMBDAS,
   parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [REQ_WIDTH-1:0] req_replica_id,
   input  logic [REQ_WIDTH-1:0] req_temp_index,
   input  logic [REQ_WIDTH-1:0] req_lambda_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_temp_label,
   output logic [OUT_WIDTH-1:0] rsp_temp_up_total,
   output logic [OUT_WIDTH-1:0] rsp_temp_down_total,
   output logic [1:0]           rsp_lambda_label,
   output logic [OUT_WIDTH-1:0] rsp_lambda_up_total,
   output logic [OUT_WIDTH-1:0] rsp_lambda_down_total
);

   localparam int RA = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
   localparam int TA = (MAX_TEMPS > 1) ? $clog2(MAX_TEMPS) : 1;
   localparam int LA = (MAX_LAMBDAS > 1) ? $clog2(MAX_LAMBDAS) : 1;
   localparam int CB = COUNT_BITS;

   // Applies one record to one ladder; returns the new label.
   function automatic logic [1:0] ladder_step(
      input  logic [1:0]    lbl,
      input  logic          is_low,
      input  logic          is_high,
      input  logic [CB-1:0] up_i,
      input  logic [CB-1:0] down_i,
      output logic [CB-1:0] up_o,
      output logic [CB-1:0] down_o
   );
      logic [CB-1:0] up_inc;
      logic [CB-1:0] down_inc;
      logic [1:0]    res;
      up_inc   = (up_i == '1) ? up_i : up_i + 1'b1;
      down_inc = (down_i == '1) ? down_i : down_i + 1'b1;
      up_o     = up_i;
      down_o   = down_i;
      unique case (lbl)
         LBL_UP: begin
            if (is_high) begin
               down_o = down_inc;
               res    = LBL_DOWN;
            end else begin
               up_o = up_inc;
               res  = LBL_UP;
            end
         end
         LBL_DOWN: begin
            if (is_low) begin
               up_o = up_inc;
               res  = LBL_UP;
            end else begin
               down_o = down_inc;
               res    = LBL_DOWN;
            end
         end
         default: begin
            // An unlabeled replica only picks up a direction at either end.
            if (is_low) begin
               res = LBL_UP;
            end else if (is_high) begin
               res = LBL_DOWN;
            end else begin
               res = LBL_NONE;
            end
         end
      endcase
      return res;
   endfunction

   // Constant tables that wrap a request field into the store depth.
   logic [RA-1:0] rep_wrap    [REQ_VALUES];
   logic [TA-1:0] temp_wrap   [REQ_VALUES];
   logic [LA-1:0] lambda_wrap [REQ_VALUES];

   for (genvar v = 0; v < REQ_VALUES; v++) begin : g_wrap
      assign rep_wrap[v]    = RA'(v % MAX_REPLICAS);
      assign temp_wrap[v]   = TA'(v % MAX_TEMPS);
      assign lambda_wrap[v] = LA'(v % MAX_LAMBDAS);
   end

   // Configuration registers.
   logic [CSR_WIDTH-1:0] temp_count_ff;
   logic [CSR_WIDTH-1:0] lambda_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_count_ff   <= COUNT_RESET;
         lambda_count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEMP_COUNT:   temp_count_ff   <= csr_wdata;
            CSR_LAMBDA_COUNT: lambda_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Ladder sizes clamped to 1..depth, and the index of the highest rung.
   logic [CLAMP_WIDTH-1:0] temp_eff;
   logic [CLAMP_WIDTH-1:0] lambda_eff;
   logic [TA-1:0]          temp_top;
   logic [LA-1:0]          lambda_top;

   always_comb begin
      if (temp_count_ff == '0) begin
         temp_eff = CLAMP_WIDTH'(1);
      end else if (CLAMP_WIDTH'(temp_count_ff) > CLAMP_WIDTH'(MAX_TEMPS)) begin
         temp_eff = CLAMP_WIDTH'(MAX_TEMPS);
      end else begin
         temp_eff = CLAMP_WIDTH'(temp_count_ff);
      end
      if (lambda_count_ff == '0) begin
         lambda_eff = CLAMP_WIDTH'(1);
      end else if (CLAMP_WIDTH'(lambda_count_ff) > CLAMP_WIDTH'(MAX_LAMBDAS)) begin
         lambda_eff = CLAMP_WIDTH'(MAX_LAMBDAS);
      end else begin
         lambda_eff = CLAMP_WIDTH'(lambda_count_ff);
      end
      temp_top   = TA'(temp_eff - CLAMP_WIDTH'(1));
      lambda_top = LA'(lambda_eff - CLAMP_WIDTH'(1));
   end

   // Handshake and pipeline control.
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic req_accept;
   logic s1_adv;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Read addresses of the request and the addresses held in the update stage.
   logic [RA-1:0] rd_rep;
   logic [TA-1:0] rd_ti;
   logic [LA-1:0] rd_li;
   logic [RA-1:0] s1_rep_ff;
   logic [TA-1:0] s1_ti_ff;
   logic [LA-1:0] s1_li_ff;

   assign rd_rep = rep_wrap[req_replica_id];
   assign rd_ti  = temp_wrap[req_temp_index];
   assign rd_li  = lambda_wrap[req_lambda_index];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rep_ff <= rd_rep;
         s1_ti_ff  <= rd_ti;
         s1_li_ff  <= rd_li;
      end
   end

   // Memories: labels by replica {lambda, temp}; counts by index {up, down}.
   logic [3:0]      lbl_mem    [MAX_REPLICAS];
   logic [2*CB-1:0] tcnt_mem   [MAX_TEMPS];
   logic [2*CB-1:0] lcnt_mem   [MAX_LAMBDAS];
   logic [3:0]      lbl_rd_ff;
   logic [2*CB-1:0] tcnt_rd_ff;
   logic [2*CB-1:0] lcnt_rd_ff;
   logic [3:0]      lbl_wr;
   logic [2*CB-1:0] tcnt_wr;
   logic [2*CB-1:0] lcnt_wr;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         lbl_mem[s1_rep_ff] <= lbl_wr;
      end
      if (req_accept) begin
         lbl_rd_ff <= lbl_mem[rd_rep];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         tcnt_mem[s1_ti_ff] <= tcnt_wr;
      end
      if (req_accept) begin
         tcnt_rd_ff <= tcnt_mem[rd_ti];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         lcnt_mem[s1_li_ff] <= lcnt_wr;
      end
      if (req_accept) begin
         lcnt_rd_ff <= lcnt_mem[rd_li];
      end
   end

   // Per-entry valid bits; an entry never written since reset reads as cleared.
   logic [MAX_REPLICAS-1:0] lbl_vld_ff;
   logic [MAX_TEMPS-1:0]    tcnt_vld_ff;
   logic [MAX_LAMBDAS-1:0]  lcnt_vld_ff;
   logic                    lbl_vrd_ff;
   logic                    tcnt_vrd_ff;
   logic                    lcnt_vrd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lbl_vld_ff  <= '0;
         tcnt_vld_ff <= '0;
         lcnt_vld_ff <= '0;
      end else if (s1_adv) begin
         lbl_vld_ff[s1_rep_ff] <= 1'b1;
         tcnt_vld_ff[s1_ti_ff] <= 1'b1;
         lcnt_vld_ff[s1_li_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         lbl_vrd_ff  <= lbl_vld_ff[rd_rep];
         tcnt_vrd_ff <= tcnt_vld_ff[rd_ti];
         lcnt_vrd_ff <= lcnt_vld_ff[rd_li];
      end
   end

   // Bypass of the last write: it lands at the same edge as the next read.
   logic            byp_valid_ff;
   logic [RA-1:0]   byp_rep_ff;
   logic [TA-1:0]   byp_ti_ff;
   logic [LA-1:0]   byp_li_ff;
   logic [3:0]      byp_lbl_ff;
   logic [2*CB-1:0] byp_tcnt_ff;
   logic [2*CB-1:0] byp_lcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         byp_rep_ff  <= s1_rep_ff;
         byp_ti_ff   <= s1_ti_ff;
         byp_li_ff   <= s1_li_ff;
         byp_lbl_ff  <= lbl_wr;
         byp_tcnt_ff <= tcnt_wr;
         byp_lcnt_ff <= lcnt_wr;
      end
   end

   // Current state for the record in the update stage.
   logic [3:0]      lbl_cur;
   logic [2*CB-1:0] tcnt_cur;
   logic [2*CB-1:0] lcnt_cur;
   logic [1:0]      temp_lbl_new;
   logic [1:0]      lambda_lbl_new;
   logic [CB-1:0]   t_up_new;
   logic [CB-1:0]   t_down_new;
   logic [CB-1:0]   l_up_new;
   logic [CB-1:0]   l_down_new;

   always_comb begin
      if (byp_valid_ff && (byp_rep_ff == s1_rep_ff)) begin
         lbl_cur = byp_lbl_ff;
      end else begin
         lbl_cur = lbl_vrd_ff ? lbl_rd_ff : {LBL_NONE, LBL_NONE};
      end
      if (byp_valid_ff && (byp_ti_ff == s1_ti_ff)) begin
         tcnt_cur = byp_tcnt_ff;
      end else begin
         tcnt_cur = tcnt_vrd_ff ? tcnt_rd_ff : '0;
      end
      if (byp_valid_ff && (byp_li_ff == s1_li_ff)) begin
         lcnt_cur = byp_lcnt_ff;
      end else begin
         lcnt_cur = lcnt_vrd_ff ? lcnt_rd_ff : '0;
      end

      temp_lbl_new = ladder_step(lbl_cur[1:0], s1_ti_ff == '0, s1_ti_ff == temp_top,
                                 tcnt_cur[2*CB-1:CB], tcnt_cur[CB-1:0],
                                 t_up_new, t_down_new);
      lambda_lbl_new = ladder_step(lbl_cur[3:2], s1_li_ff == '0, s1_li_ff == lambda_top,
                                   lcnt_cur[2*CB-1:CB], lcnt_cur[CB-1:0],
                                   l_up_new, l_down_new);

      lbl_wr  = {lambda_lbl_new, temp_lbl_new};
      tcnt_wr = {t_up_new, t_down_new};
      lcnt_wr = {l_up_new, l_down_new};
   end

   // Output register.
   logic [1:0]           rsp_temp_label_ff;
   logic [OUT_WIDTH-1:0] rsp_temp_up_ff;
   logic [OUT_WIDTH-1:0] rsp_temp_down_ff;
   logic [1:0]           rsp_lambda_label_ff;
   logic [OUT_WIDTH-1:0] rsp_lambda_up_ff;
   logic [OUT_WIDTH-1:0] rsp_lambda_down_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_temp_label_ff   <= temp_lbl_new;
         rsp_temp_up_ff      <= OUT_WIDTH'(t_up_new);
         rsp_temp_down_ff    <= OUT_WIDTH'(t_down_new);
         rsp_lambda_label_ff <= lambda_lbl_new;
         rsp_lambda_up_ff    <= OUT_WIDTH'(l_up_new);
         rsp_lambda_down_ff  <= OUT_WIDTH'(l_down_new);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temp_label        = rsp_temp_label_ff;
   assign rsp_temp_up_total     = rsp_temp_up_ff;
   assign rsp_temp_down_total   = rsp_temp_down_ff;
   assign rsp_lambda_label      = rsp_lambda_label_ff;
   assign rsp_lambda_up_total   = rsp_lambda_up_ff;
   assign rsp_lambda_down_total = rsp_lambda_down_ff;

   // A full update stage behind a stalled response must hold off new requests.
   `RTDH_ASSERT_SAME(a_hold_when_full, clock, reset,
      s1_valid_ff && rsp_valid_ff && rsp_stall, req_stall,
      "request taken while the update stage could not drain")

   // A record leaving the update stage is presented as a response next cycle.
   `RTDH_ASSERT_NEXT(a_adv_to_rsp, clock, reset, s1_adv, rsp_valid_ff,
      "updated record did not reach the response register")

   // Labels written back never carry the unused code.
   `RTDH_ASSERT_SAME(a_label_code, clock, reset, s1_adv,
      (temp_lbl_new != 2'd3) && (lambda_lbl_new != 2'd3),
      "invalid direction label produced")

endmodule
